/* hdl/cle_pkg.sv */
// shared types, constants and codes of the circular list engine
package cle_pkg;

   localparam int CAPACITY  = 64;
   localparam int SLOT_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int GROUPS    = (CAPACITY + 7) / 8;
   localparam int VALUE_W   = 32;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef enum logic [2:0] {
      OP_INS_FIRST = 3'd0,
      OP_INS_LAST  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_LAST  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_READ_ALL  = 3'd6,
      OP_NONE      = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_INVALID = 3'd1,
      STAT_BOUNDS  = 3'd2,
      STAT_EMPTY   = 3'd3,
      STAT_FULL    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_WALK,
      S_END,
      S_FIX
   } state_type;

   typedef enum logic [2:0] {
      K_INS_HEAD,
      K_INS_MID,
      K_DEL_HEAD,
      K_DEL_MID,
      K_READ
   } kind_type;

   typedef struct packed {
      logic     take;
      slot_type take_slot;
      logic     give;
      slot_type give_slot;
   } free_cmd_type;

endpackage

/* hdl/cle_ram.sv */
// generic single write port ram with registered read
module cle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/cle_free_map.sv */
// free slot map with a registered lowest-free-slot search
module cle_free_map (
   input  logic                    clock,
   input  logic                    reset,
   input  cle_pkg::free_cmd_type   free_cmd,
   output cle_pkg::slot_type       alloc_slot
);

   logic [cle_pkg::CAPACITY-1:0]   free_ff, free_in;
   logic [cle_pkg::GROUPS*8-1:0]   padded;
   logic [cle_pkg::GROUPS-1:0]     any_ff, any_in;
   logic [2:0]                     idx_ff [cle_pkg::GROUPS];
   logic [2:0]                     idx_in [cle_pkg::GROUPS];

   always_comb begin
      free_in = free_ff;
      if (free_cmd.take) begin
         free_in[free_cmd.take_slot] = 1'b0;
      end
      if (free_cmd.give) begin
         free_in[free_cmd.give_slot] = 1'b1;
      end
   end

   // first stage of the search: lowest free bit in each group of eight
   always_comb begin
      padded = '0;
      padded[cle_pkg::CAPACITY-1:0] = free_ff;
      for (int g = 0; g < cle_pkg::GROUPS; g++) begin
         any_in[g] = |padded[g*8 +: 8];
         idx_in[g] = 3'd0;
         for (int i = 7; i >= 0; i--) begin
            if (padded[g*8 + i]) begin
               idx_in[g] = 3'(i);
            end
         end
      end
   end

   // second stage: lowest group that has a free slot
   always_comb begin
      alloc_slot = '0;
      for (int g = cle_pkg::GROUPS - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            alloc_slot = cle_pkg::SLOT_W'(g * 8 + int'(idx_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      any_ff <= any_in;
      idx_ff <= idx_in;
   end

endmodule

/* hdl/circular_list_engine.sv */
// circular linked list engine: sequencer over the link and value memories
//
//   channel   ports                                           transfer
//   request   start, busy, req_op, req_value, req_position   start & !busy
//   response  rsp_strobe, rsp_status, rsp_element,           rsp_strobe
//             rsp_last, rsp_count
//
// rejected requests, an empty read, a delete from a one-entry list and unused ops answer
// in the cycle after the transfer and leave busy low. otherwise busy stays high while the
// sequencer runs alloc and, on a non-empty list, fix for an insert at the head; alloc, the
// link walk, end and fix for an insert at a later position; the walk and end for a delete
// or a read. the walk makes one link memory read a cycle. the last response comes in the
// same cycle as busy falls. reset clears the list at once. the response side cannot stall.
module circular_list_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_position,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic               rsp_last,
   output logic [6:0]         rsp_count
);

   cle_pkg::state_type     state_ff, state_in;
   cle_pkg::kind_type      kind_ff, kind_in;
   cle_pkg::slot_type      first_ff, first_in;
   cle_pkg::slot_type      last_ff, last_in;
   cle_pkg::count_type     held_ff, held_in;
   cle_pkg::count_type     steps_ff, steps_in;
   cle_pkg::slot_type      cur_ff, cur_in;
   cle_pkg::slot_type      prev_ff, prev_in;
   cle_pkg::slot_type      slot_ff, slot_in;
   logic                   walk_first_ff, walk_first_in;
   logic                   pend_ff, pend_in;
   logic                   pend_last_ff, pend_last_in;
   logic [31:0]            value_ff, value_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   cle_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_element_ff, rsp_element_in;
   logic                   rsp_last_ff, rsp_last_in;
   cle_pkg::count_type     rsp_count_ff, rsp_count_in;

   logic                   lk_we;
   cle_pkg::slot_type      lk_waddr, lk_wdata, lk_raddr, lk_rdata;
   logic                   vl_we;
   logic [31:0]            vl_rdata;

   cle_pkg::free_cmd_type  free_cmd;
   cle_pkg::slot_type      alloc_slot;

   logic                   accept;
   logic [7:0]             pos8, held8;
   cle_pkg::status_type    stat;
   cle_pkg::count_type     held_p1, held_m1;

   cle_ram #(.WIDTH(cle_pkg::SLOT_W), .DEPTH(cle_pkg::CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_we),
      .wr_addr (lk_waddr),
      .wr_data (lk_wdata),
      .rd_addr (lk_raddr),
      .rd_data (lk_rdata)
   );

   cle_ram #(.WIDTH(cle_pkg::VALUE_W), .DEPTH(cle_pkg::CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (vl_we),
      .wr_addr (slot_in),
      .wr_data (value_ff),
      .rd_addr (lk_raddr),
      .rd_data (vl_rdata)
   );

   cle_free_map u_free_map (
      .clock      (clock),
      .reset      (reset),
      .free_cmd   (free_cmd),
      .alloc_slot (alloc_slot)
   );

   assign busy    = (state_ff != cle_pkg::S_IDLE);
   assign accept  = start && !busy;
   assign held8   = 8'(held_ff);
   assign held_p1 = held_ff + cle_pkg::CNT_W'(1);
   assign held_m1 = held_ff - cle_pkg::CNT_W'(1);

   // effective position and status of the offered request
   always_comb begin
      case (cle_pkg::op_type'(req_op))
         cle_pkg::OP_INS_FIRST: pos8 = 8'd1;
         cle_pkg::OP_INS_LAST:  pos8 = held8 + 8'd1;
         cle_pkg::OP_INS_AT:    pos8 = 8'(req_position);
         cle_pkg::OP_DEL_FIRST: pos8 = 8'd1;
         cle_pkg::OP_DEL_LAST:  pos8 = held8;
         cle_pkg::OP_DEL_AT:    pos8 = 8'(req_position);
         default:               pos8 = 8'd0;
      endcase
      stat = cle_pkg::STAT_OK;
      case (cle_pkg::op_type'(req_op))
         cle_pkg::OP_INS_FIRST, cle_pkg::OP_INS_LAST, cle_pkg::OP_INS_AT: begin
            if (pos8 == 8'd0) begin
               stat = cle_pkg::STAT_INVALID;
            end else if (pos8 > held8 + 8'd1) begin
               stat = cle_pkg::STAT_BOUNDS;
            end else if (held8 >= 8'(cle_pkg::CAPACITY)) begin
               stat = cle_pkg::STAT_FULL;
            end
         end
         cle_pkg::OP_DEL_FIRST, cle_pkg::OP_DEL_LAST, cle_pkg::OP_DEL_AT: begin
            if (held8 == 8'd0 && cle_pkg::op_type'(req_op) != cle_pkg::OP_DEL_AT) begin
               stat = cle_pkg::STAT_EMPTY;
            end else if (pos8 == 8'd0) begin
               stat = cle_pkg::STAT_INVALID;
            end else if (held8 == 8'd0) begin
               stat = cle_pkg::STAT_EMPTY;
            end else if (pos8 > held8) begin
               stat = cle_pkg::STAT_BOUNDS;
            end
         end
         cle_pkg::OP_READ_ALL: begin
            if (held8 == 8'd0) begin
               stat = cle_pkg::STAT_EMPTY;
            end
         end
         default: stat = cle_pkg::STAT_OK;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      held_in       = held_ff;
      steps_in      = steps_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      slot_in       = slot_ff;
      walk_first_in = walk_first_ff;
      pend_in       = 1'b0;
      pend_last_in  = 1'b0;
      value_in      = value_ff;
      lk_we         = 1'b0;
      lk_waddr      = '0;
      lk_wdata      = '0;
      lk_raddr      = first_ff;
      vl_we         = 1'b0;
      free_cmd      = '0;

      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_count_in   = rsp_count_ff;

      // read-all values leave the value memory in the cycle after their read
      if (pend_ff) begin
         rsp_strobe_in  = 1'b1;
         rsp_status_in  = cle_pkg::STAT_OK;
         rsp_element_in = vl_rdata;
         rsp_last_in    = pend_last_ff;
         rsp_count_in   = held_ff;
      end

      case (state_ff)
         cle_pkg::S_IDLE: begin
            if (accept) begin
               value_in      = req_value;
               walk_first_in = 1'b1;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               rsp_status_in  = stat;
               rsp_count_in   = held_ff;
               if (stat != cle_pkg::STAT_OK) begin
                  rsp_strobe_in = 1'b1;
               end else begin
                  case (cle_pkg::op_type'(req_op))
                     cle_pkg::OP_INS_FIRST, cle_pkg::OP_INS_LAST,
                     cle_pkg::OP_INS_AT: begin
                        kind_in  = (pos8 == 8'd1 || held8 == 8'd0) ?
                                   cle_pkg::K_INS_HEAD : cle_pkg::K_INS_MID;
                        steps_in = cle_pkg::CNT_W'(pos8 - 8'd1);
                        state_in = cle_pkg::S_ALLOC;
                     end
                     cle_pkg::OP_DEL_FIRST, cle_pkg::OP_DEL_LAST,
                     cle_pkg::OP_DEL_AT: begin
                        if (held8 == 8'd1) begin
                           free_cmd.give      = 1'b1;
                           free_cmd.give_slot = first_ff;
                           first_in           = '0;
                           last_in            = '0;
                           held_in            = '0;
                           rsp_strobe_in      = 1'b1;
                           rsp_count_in       = '0;
                        end else begin
                           kind_in  = (pos8 == 8'd1) ? cle_pkg::K_DEL_HEAD :
                                                       cle_pkg::K_DEL_MID;
                           steps_in = cle_pkg::CNT_W'(pos8);
                           state_in = cle_pkg::S_WALK;
                        end
                     end
                     cle_pkg::OP_READ_ALL: begin
                        kind_in  = cle_pkg::K_READ;
                        steps_in = held_ff;
                        state_in = cle_pkg::S_WALK;
                     end
                     default: begin
                        rsp_strobe_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         cle_pkg::S_ALLOC: begin
            slot_in            = alloc_slot;
            vl_we              = 1'b1;
            free_cmd.take      = 1'b1;
            free_cmd.take_slot = alloc_slot;
            if (kind_ff == cle_pkg::K_INS_HEAD) begin
               lk_we    = 1'b1;
               lk_waddr = alloc_slot;
               if (held_ff == '0) begin
                  lk_wdata      = alloc_slot;
                  first_in      = alloc_slot;
                  last_in       = alloc_slot;
                  held_in       = held_p1;
                  rsp_strobe_in = 1'b1;
                  rsp_count_in  = held_p1;
                  state_in      = cle_pkg::S_IDLE;
               end else begin
                  lk_wdata = first_ff;
                  state_in = cle_pkg::S_FIX;
               end
            end else begin
               state_in = cle_pkg::S_WALK;
            end
         end
         cle_pkg::S_WALK: begin
            lk_raddr      = walk_first_ff ? first_ff : lk_rdata;
            cur_in        = lk_raddr;
            prev_in       = cur_ff;
            walk_first_in = 1'b0;
            steps_in      = steps_ff - cle_pkg::CNT_W'(1);
            if (kind_ff == cle_pkg::K_READ) begin
               pend_in      = 1'b1;
               pend_last_in = (steps_ff == cle_pkg::CNT_W'(1));
            end
            if (steps_ff == cle_pkg::CNT_W'(1)) begin
               state_in = cle_pkg::S_END;
            end
         end
         cle_pkg::S_END: begin
            state_in = cle_pkg::S_IDLE;
            case (kind_ff)
               cle_pkg::K_INS_MID: begin
                  lk_we    = 1'b1;
                  lk_waddr = slot_ff;
                  lk_wdata = lk_rdata;
                  state_in = cle_pkg::S_FIX;
               end
               cle_pkg::K_DEL_HEAD: begin
                  lk_we              = 1'b1;
                  lk_waddr           = last_ff;
                  lk_wdata           = lk_rdata;
                  first_in           = lk_rdata;
                  free_cmd.give      = 1'b1;
                  free_cmd.give_slot = cur_ff;
                  held_in            = held_m1;
                  rsp_strobe_in      = 1'b1;
                  rsp_count_in       = held_m1;
               end
               cle_pkg::K_DEL_MID: begin
                  lk_we              = 1'b1;
                  lk_waddr           = prev_ff;
                  lk_wdata           = lk_rdata;
                  if (cur_ff == last_ff) begin
                     last_in = prev_ff;
                  end
                  free_cmd.give      = 1'b1;
                  free_cmd.give_slot = cur_ff;
                  held_in            = held_m1;
                  rsp_strobe_in      = 1'b1;
                  rsp_count_in       = held_m1;
               end
               default: state_in = cle_pkg::S_IDLE;
            endcase
         end
         cle_pkg::S_FIX: begin
            lk_we         = 1'b1;
            lk_wdata      = slot_ff;
            held_in       = held_p1;
            rsp_strobe_in = 1'b1;
            rsp_count_in  = held_p1;
            state_in      = cle_pkg::S_IDLE;
            if (kind_ff == cle_pkg::K_INS_HEAD) begin
               lk_waddr = last_ff;
               first_in = slot_ff;
            end else begin
               lk_waddr = cur_ff;
               if (cur_ff == last_ff) begin
                  last_in = slot_ff;
               end
            end
         end
         default: state_in = cle_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cle_pkg::S_IDLE;
         first_ff      <= '0;
         last_ff       <= '0;
         held_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         held_ff       <= held_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      steps_ff       <= steps_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      slot_ff        <= slot_in;
      walk_first_ff  <= walk_first_in;
      pend_last_ff   <= pend_last_in;
      value_ff       <= value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_count   = 7'(rsp_count_ff);

endmodule

/* bench/tb_circular_list_engine.sv */
// testbench for circular_list_engine: directed and random list requests with a list predictor
module tb_circular_list_engine;

   typedef struct {
      logic [2:0]         status;
      logic signed [31:0] element;
      logic               last;
      logic [6:0]         count;
   } answer_type;

   class list_scoreboard;
      logic signed [31:0] contents[$];
      answer_type         answers[$];
      int                 errors;

      function int held();
         return contents.size();
      endfunction

      function int pending();
         return answers.size();
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      function void push_answer(cle_pkg::status_type st, logic signed [31:0] elem,
                                logic lst);
         answer_type a;
         a.status  = st;
         a.element = elem;
         a.last    = lst;
         a.count   = 7'(contents.size());
         answers.push_back(a);
      endfunction

      function cle_pkg::status_type place_value(logic signed [31:0] v, int p);
         if (p == 0) return cle_pkg::STAT_INVALID;
         if (p > contents.size() + 1) return cle_pkg::STAT_BOUNDS;
         if (contents.size() >= cle_pkg::CAPACITY) return cle_pkg::STAT_FULL;
         contents.insert(p - 1, v);
         return cle_pkg::STAT_OK;
      endfunction

      function cle_pkg::status_type remove_value(int p);
         if (p == 0) return cle_pkg::STAT_INVALID;
         if (contents.size() == 0) return cle_pkg::STAT_EMPTY;
         if (p > contents.size()) return cle_pkg::STAT_BOUNDS;
         contents.delete(p - 1);
         return cle_pkg::STAT_OK;
      endfunction

      // works out every response that one accepted request causes
      function void note_request(logic [2:0] code, logic signed [31:0] v, logic [6:0] p);
         cle_pkg::status_type st;
         int                  n;
         st = cle_pkg::STAT_OK;
         n  = contents.size();
         case (cle_pkg::op_type'(code))
            cle_pkg::OP_INS_FIRST: st = place_value(v, 1);
            cle_pkg::OP_INS_LAST:  st = place_value(v, n + 1);
            cle_pkg::OP_INS_AT:    st = place_value(v, int'(p));
            cle_pkg::OP_DEL_FIRST: st = (n == 0) ? cle_pkg::STAT_EMPTY : remove_value(1);
            cle_pkg::OP_DEL_LAST:  st = (n == 0) ? cle_pkg::STAT_EMPTY : remove_value(n);
            cle_pkg::OP_DEL_AT:    st = remove_value(int'(p));
            cle_pkg::OP_READ_ALL: begin
               if (n == 0) begin
                  push_answer(cle_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  foreach (contents[i])
                     push_answer(cle_pkg::STAT_OK, contents[i], i == n - 1);
               end
               return;
            end
            default: st = cle_pkg::STAT_OK;
         endcase
         push_answer(st, '0, 1'b1);
      endfunction

      task check_result(logic [2:0] st, logic signed [31:0] elem, logic lst,
                        logic [6:0] cnt);
         answer_type a;
         if (answers.size() == 0) begin
            report($sformatf("unexpected response status %0d element %0d last %0d count %0d",
                             st, elem, lst, cnt));
            return;
         end
         a = answers.pop_front();
         if (st !== a.status || elem !== a.element || lst !== a.last || cnt !== a.count)
            report($sformatf({"got status %0d element %0d last %0d count %0d, ",
                              "expected %0d %0d %0d %0d"},
                             st, elem, lst, cnt, a.status, a.element, a.last, a.count));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_op;
   logic signed [31:0] req_value;
   logic [6:0]         req_position;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_element;
   logic               rsp_last;
   logic [6:0]         rsp_count;

   list_scoreboard sb = new();
   bit             no_idle;

   circular_list_engine uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_count    (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_status, rsp_element, rsp_last, rsp_count);
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task send_request(logic [2:0] op, logic signed [31:0] v, logic [6:0] p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op       = op;
      req_value    = v;
      req_position = p;
      start        = 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(op, v, p);
      @(negedge clock);
   endtask

   initial begin
      cle_pkg::op_type    ins_kinds[3] = '{cle_pkg::OP_INS_FIRST, cle_pkg::OP_INS_LAST,
                                           cle_pkg::OP_INS_AT};
      cle_pkg::op_type    del_kinds[3] = '{cle_pkg::OP_DEL_FIRST, cle_pkg::OP_DEL_LAST,
                                           cle_pkg::OP_DEL_AT};
      logic [2:0]         op;
      logic signed [31:0] v;
      logic [6:0]         p;
      int                 n;
      int                 roll;
      bit                 growing;
      reset        = 1'b1;
      start        = 1'b0;
      req_op       = '0;
      req_value    = '0;
      req_position = '0;
      no_idle      = 1'b0;
      growing      = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list, rejected positions, extremes of the value field
      send_request(cle_pkg::OP_READ_ALL, 0, 0);
      send_request(cle_pkg::OP_DEL_FIRST, 0, 0);
      send_request(cle_pkg::OP_DEL_LAST, 0, 0);
      send_request(cle_pkg::OP_DEL_AT, 0, 0);
      send_request(cle_pkg::OP_DEL_AT, 0, 1);
      send_request(cle_pkg::OP_INS_AT, 32'sd11, 0);
      send_request(cle_pkg::OP_INS_AT, 32'sd12, 2);
      send_request(cle_pkg::OP_INS_AT, 32'sh7FFF_FFFF, 1);
      send_request(cle_pkg::OP_INS_FIRST, 32'sh8000_0000, 0);
      send_request(cle_pkg::OP_INS_LAST, 32'sd0, 0);
      send_request(cle_pkg::OP_INS_AT, 32'shFFFF_FFFF, 4);
      send_request(cle_pkg::OP_INS_AT, 32'sh5555_5555, 3);
      send_request(cle_pkg::OP_INS_AT, 32'shAAAA_AAAA, 7);
      send_request(cle_pkg::OP_READ_ALL, 0, 0);
      send_request(cle_pkg::OP_DEL_AT, 0, 6);
      send_request(cle_pkg::OP_DEL_AT, 0, 3);
      send_request(cle_pkg::OP_DEL_AT, 0, 127);
      send_request(cle_pkg::OP_NONE, 32'sh1234_5678, 127);
      send_request(cle_pkg::OP_DEL_LAST, 0, 0);
      send_request(cle_pkg::OP_DEL_FIRST, 0, 0);
      send_request(cle_pkg::OP_READ_ALL, 0, 0);
      send_request(cle_pkg::OP_DEL_AT, 0, 2);
      send_request(cle_pkg::OP_DEL_LAST, 0, 0);
      send_request(cle_pkg::OP_READ_ALL, 0, 0);

      // fill to the top and drain again, with some noise
      for (int i = 0; i < 206; i++) begin
         if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
         n = sb.held();
         if (n == cle_pkg::CAPACITY) growing = 1'b0;
         else if (n == 0) growing = 1'b1;
         roll = $urandom_range(0, 99);
         v    = $urandom;
         if (roll < 6) begin
            op = 3'($urandom_range(0, 7));
            p  = 7'($urandom_range(0, 127));
         end else if (roll < 12) begin
            op = cle_pkg::OP_READ_ALL;
            p  = 7'($urandom_range(0, 127));
         end else if (growing == (roll < 90)) begin
            op = ins_kinds[$urandom_range(0, 2)];
            p  = 7'($urandom_range(1, n + 1));
         end else begin
            op = del_kinds[$urandom_range(0, 2)];
            p  = (n == 0) ? 7'd1 : 7'($urandom_range(1, n));
         end
         send_request(op, v, p);
      end
      start = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
